[src/swbs_pkg.sv]
// ----------------------------------------------------------------------------
// swbs_pkg
// Types and codes shared by the sliding window bitmap store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swbs_pkg;

  // Operation codes carried in the opcode field of an input word.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               write_bit;
  } in_item_t;

  typedef struct packed {
    logic read_bit;
    logic in_window;
  } out_item_t;

  // Step strobes from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sub;
    logic addr;
    logic commit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[src/sliding_window_bitmap_store.sv]
// ----------------------------------------------------------------------------
// sliding_window_bitmap_store
// Occupancy bitmap on a torus with a sliding window around written cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid/in_ready    opcode, x_coord, y_coord, write_bit
//   out_     output     out_valid/out_ready  read_bit, in_window
//
// Each word occupies the block through the accept cycle, two multiply steps
// of the torus index arithmetic, a subtract, an address step, and the read and
// write-back of one map byte through the single RAM port. Its result is
// loaded into the output register in the final step, after which the block
// is idle again and can accept the next word.
// After reset a clearing pass writes zero to every map byte, one byte a cycle,
// in all GRID_CELLS * ceil(GRID_CELLS / 8) bytes (8192 at the default);
// in_ready stays low throughout.
// A waiting result does not stop the next word being accepted; that word only
// holds in its final step until the output register has been taken.
//
`default_nettype none

module sliding_window_bitmap_store #(
  parameter int GRID_CELLS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire swbs_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output swbs_pkg::out_item_t      out_item
);

  // The controller only sequences; every value lives in the datapath.
  swbs_pkg::ctrl_cmd_t cmd;
  swbs_pkg::ctrl_sts_t sts;

  swbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath checks the window against the state as it stood before the
  // word, so the window is refreshed only after the compare has been taken.
  swbs_datapath #(
    .GRID_CELLS (GRID_CELLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

[src/swbs_ram.sv]
// ----------------------------------------------------------------------------
// swbs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[src/swbs_ctrl.sv]
// ----------------------------------------------------------------------------
// swbs_ctrl
// Sequencer for the bitmap store: clearing pass, item steps and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module swbs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire swbs_pkg::ctrl_sts_t  sts,
  output swbs_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUB,
    S_ADDR,
    S_RD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/swbs_datapath.sv]
// ----------------------------------------------------------------------------
// swbs_datapath
// Window check, torus index arithmetic, bounding box, map RAM and result.
// ----------------------------------------------------------------------------
`default_nettype none

module swbs_datapath #(
  parameter int GRID_CELLS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swbs_pkg::ctrl_cmd_t  cmd,
  input  wire swbs_pkg::in_item_t   in_item,
  output swbs_pkg::ctrl_sts_t       sts,
  output swbs_pkg::out_item_t       out_item
);

  localparam int RB    = (GRID_CELLS + 7) / 8;
  localparam int DEPTH = GRID_CELLS * RB;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_CELLS);
  // Bias that makes any coordinate non-negative while keeping its residue.
  localparam int OFFS  = ((32768 + GRID_CELLS - 1) / GRID_CELLS) * GRID_CELLS;
  localparam int UADD  = GRID_CELLS / 2 + OFFS;
  localparam int UW    = 17;
  localparam int SH    = UW + RW + 1;
  localparam int MW    = UW + 2;
  localparam int PW    = UW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(GRID_CELLS) - 64'd1) / 64'(GRID_CELLS));
  localparam logic signed [15:0] WIN_LO_RST = 16'(1 - GRID_CELLS);
  localparam logic signed [15:0] WIN_HI_RST = 16'(GRID_CELLS - 1);

  logic [1:0]         op_r;
  logic               wbit_r;
  logic               inside_r;
  logic signed [15:0] x_r, y_r;
  logic [UW-1:0]      ux_r, uy_r;
  logic [PW-1:0]      px_r, py_r;
  logic [UW-1:0]      qgx_r, qgy_r;
  logic [RW-1:0]      row_r, col_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      clr_cnt_r;
  logic signed [15:0] bx_min_r, bx_max_r, by_min_r, by_max_r;
  logic signed [15:0] wx_lo_r, wx_hi_r, wy_lo_r, wy_hi_r;
  swbs_pkg::out_item_t out_r;

  logic               win_hit;
  logic [17:0]        usx, usy;
  logic [UW-1:0]      qx, qy;
  logic [UW-1:0]      rx, ry;
  logic [7:0]         rdata, wdata;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [2:0]         bit_sel;
  logic               stored_bit;
  logic               wr_hit;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v < -20'sd32768) begin
      return -16'sd32768;
    end else if (v > 20'sd32767) begin
      return 16'sd32767;
    end
    return v[15:0];
  endfunction

  // Window reaches (GRID_CELLS - span) cells beyond each side of the box.
  function automatic logic signed [15:0] win_bound(input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi,
                                                   input logic high_side);
    logic signed [19:0] lo_e, hi_e, slack;
    lo_e  = {{4{lo[15]}}, lo};
    hi_e  = {{4{hi[15]}}, hi};
    slack = 20'(GRID_CELLS) - (hi_e - lo_e + 20'sd1);
    return high_side ? sat16(hi_e + slack) : sat16(lo_e - slack);
  endfunction

  assign win_hit = (in_item.x_coord >= wx_lo_r) && (in_item.x_coord <= wx_hi_r) &&
                   (in_item.y_coord >= wy_lo_r) && (in_item.y_coord <= wy_hi_r);

  assign usx = {{2{in_item.x_coord[15]}}, in_item.x_coord} + 18'(UADD);
  assign usy = {{2{in_item.y_coord[15]}}, in_item.y_coord} + 18'(UADD);

  // Quotient by reciprocal is exact over the whole biased range.
  assign qx = UW'(px_r >> SH);
  assign qy = UW'(py_r >> SH);
  assign rx = ux_r - qgx_r;
  assign ry = uy_r - qgy_r;

  assign wr_hit     = (op_r == swbs_pkg::OP_WRITE) && inside_r;
  assign bit_sel    = ~col_r[2:0];
  assign stored_bit = rdata[bit_sel];

  always_comb begin
    wdata          = rdata;
    wdata[bit_sel] = wbit_r;
    if (cmd.clear) begin
      wdata = '0;
    end
  end

  assign ram_we   = cmd.clear || (cmd.commit && wr_hit);
  assign ram_addr = cmd.clear ? clr_cnt_r : addr_r;

  swbs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign out_item     = out_r;

  // Item path registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_item.opcode;
      wbit_r   <= in_item.write_bit;
      inside_r <= win_hit;
      x_r      <= in_item.x_coord;
      y_r      <= in_item.y_coord;
      ux_r     <= usx[UW-1:0];
      uy_r     <= usy[UW-1:0];
    end
    if (cmd.mul1) begin
      px_r <= PW'(ux_r) * PW'(RECIP);
      py_r <= PW'(uy_r) * PW'(RECIP);
    end
    if (cmd.mul2) begin
      qgx_r <= qx * UW'(GRID_CELLS);
      qgy_r <= qy * UW'(GRID_CELLS);
    end
    if (cmd.sub) begin
      row_r <= rx[RW-1:0];
      col_r <= ry[RW-1:0];
    end
    if (cmd.addr) begin
      addr_r <= AW'(row_r) * AW'(RB) + AW'(col_r >> 3);
    end
    if (cmd.commit) begin
      out_r.read_bit  <= (op_r == swbs_pkg::OP_READ) ? (inside_r ? stored_bit : 1'b1)
                                                     : 1'b0;
      out_r.in_window <= ((op_r == swbs_pkg::OP_READ) || (op_r == swbs_pkg::OP_WRITE))
                         && inside_r;
    end
  end

  // Bounding box, window and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      bx_min_r  <= '0;
      bx_max_r  <= '0;
      by_min_r  <= '0;
      by_max_r  <= '0;
      wx_lo_r   <= WIN_LO_RST;
      wx_hi_r   <= WIN_HI_RST;
      wy_lo_r   <= WIN_LO_RST;
      wy_hi_r   <= WIN_HI_RST;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.mul1) begin
        if (op_r == swbs_pkg::OP_RESTART) begin
          bx_min_r <= '0;
          bx_max_r <= '0;
          by_min_r <= '0;
          by_max_r <= '0;
        end else if (wr_hit) begin
          if (x_r < bx_min_r) begin
            bx_min_r <= x_r;
          end else if (x_r > bx_max_r) begin
            bx_max_r <= x_r;
          end
          if (y_r < by_min_r) begin
            by_min_r <= y_r;
          end else if (y_r > by_max_r) begin
            by_max_r <= y_r;
          end
        end
      end
      if (cmd.mul2) begin
        wx_lo_r <= win_bound(bx_min_r, bx_max_r, 1'b0);
        wx_hi_r <= win_bound(bx_min_r, bx_max_r, 1'b1);
        wy_lo_r <= win_bound(by_min_r, by_max_r, 1'b0);
        wy_hi_r <= win_bound(by_min_r, by_max_r, 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

[src/swbs_checker.sv]
// ----------------------------------------------------------------------------
// swbs_checker
// Port-level checks on the sliding window bitmap store, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module swbs_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire swbs_pkg::out_item_t out_item
);

  // A result that has not been taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result word changed or dropped while stalled");

  // Only one word is in work at a time.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  // A new result appears only at the end of a word's work.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind sliding_window_bitmap_store swbs_checker u_swbs_checker (.*);

`default_nettype wire

[test/sliding_window_bitmap_store_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_bitmap_store_tb
// Self-checking testbench for the sliding window bitmap store.
// Read, write, restart and unused words go in over the valid/ready input. A
// predictor keeps its own occupancy map, bounding box and window, works out
// the result of every accepted word, and each result word that leaves the
// block is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module sliding_window_bitmap_store_tb;

  localparam int GRID_CELLS = 256;
  localparam int CLK_PERIOD = 10;
  // Time that one word occupies the block with no output stall, over the
  // steps that the block's header describes.
  localparam int LATENCY = 7;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RECENT_CELLS = 32;
  // The package names three operations; the fourth code must do nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    swbs_pkg::in_item_t  word;
    swbs_pkg::out_item_t result;
  } cell_expectation_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  swbs_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swbs_pkg::out_item_t out_item;

  sliding_window_bitmap_store #(
    .GRID_CELLS(GRID_CELLS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Clock and the overall time limit. The limit allows for the clearing pass
  // after reset plus every word meeting the longest gaps on both sides, with
  // a good margin on top.
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predicted state of the block. The map is held as one bit per cell, rows
  // and columns already wrapped onto the torus; how the block packs bits into
  // bytes does not show at its ports.
  // --------------------------------------------------------------------------
  bit                 occupancy [GRID_CELLS][GRID_CELLS];
  logic signed [15:0] box_x_lo, box_x_hi, box_y_lo, box_y_hi;
  logic signed [15:0] win_x_lo, win_x_hi, win_y_lo, win_y_hi;

  // Cells written recently, so that a good share of reads land on them.
  logic [31:0]        recent_cells [$];
  cell_expectation_t  pending_results [$];

  // Run statistics and failure counts.
  int words_sent, results_seen, failures, mismatches;
  int n_reads, n_reads_inside, n_writes, n_writes_taken, n_restarts, n_unused;
  int widest_span;

  // Idling controls shared between the test tasks and the two sides.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_off_request = 0;

  function automatic logic signed [15:0] clamp_coord(int v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7FFF;
    return 16'(v);
  endfunction

  // On each axis the window reaches as far beyond the box as the box is
  // short of the full grid, saturating at the ends of the coordinate range.
  function automatic void window_around(input logic signed [15:0] lo, hi,
                                        output logic signed [15:0] wlo, whi);
    int slack;
    slack = GRID_CELLS - (int'(hi) - int'(lo) + 1);
    wlo = clamp_coord(int'(lo) - slack);
    whi = clamp_coord(int'(hi) + slack);
  endfunction

  function automatic void refresh_windows();
    window_around(box_x_lo, box_x_hi, win_x_lo, win_x_hi);
    window_around(box_y_lo, box_y_hi, win_y_lo, win_y_hi);
  endfunction

  function automatic void recentre_box();
    box_x_lo = '0;
    box_x_hi = '0;
    box_y_lo = '0;
    box_y_hi = '0;
    refresh_windows();
  endfunction

  // Row or column on the torus, with the origin sitting half a grid in.
  function automatic int torus_index(logic signed [15:0] c);
    int r;
    r = (int'(c) + GRID_CELLS + GRID_CELLS / 2) % GRID_CELLS;
    if (r < 0) r += GRID_CELLS;
    return r;
  endfunction

  // Applies one accepted word to the predicted state and returns the result
  // word that the block ought to produce for it. The window test always uses
  // the window as it stood before the word.
  function automatic swbs_pkg::out_item_t apply_word(swbs_pkg::in_item_t w);
    swbs_pkg::out_item_t res;
    logic signed [15:0]  x, y;
    logic                in_win;
    int                  row, col;
    res = '0;
    x = w.x_coord;
    y = w.y_coord;
    in_win = (x >= win_x_lo) && (x <= win_x_hi) && (y >= win_y_lo) && (y <= win_y_hi);
    row = torus_index(x);
    col = torus_index(y);
    case (w.opcode)
      swbs_pkg::OP_READ: begin
        // Cells outside the window are unknown and so count as occupied.
        res.in_window = in_win;
        res.read_bit = in_win ? occupancy[row][col] : 1'b1;
        n_reads++;
        if (in_win) n_reads_inside++;
      end
      swbs_pkg::OP_WRITE: begin
        res.in_window = in_win;
        n_writes++;
        if (in_win) begin
          // A write of zero still widens the box and moves the window.
          if (x < box_x_lo) box_x_lo = x;
          else if (x > box_x_hi) box_x_hi = x;
          if (y < box_y_lo) box_y_lo = y;
          else if (y > box_y_hi) box_y_hi = y;
          refresh_windows();
          occupancy[row][col] = w.write_bit;
          n_writes_taken++;
          if (int'(box_x_hi) - int'(box_x_lo) + 1 > widest_span)
            widest_span = int'(box_x_hi) - int'(box_x_lo) + 1;
          if (int'(box_y_hi) - int'(box_y_lo) + 1 > widest_span)
            widest_span = int'(box_y_hi) - int'(box_y_lo) + 1;
          recent_cells.push_back({x, y});
          if (recent_cells.size() > RECENT_CELLS) void'(recent_cells.pop_front());
        end
      end
      swbs_pkg::OP_RESTART: begin
        // The box goes back to the origin; the map keeps its contents.
        recentre_box();
        n_restarts++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinates cluster around the current window, with a fair share right
  // on its edges, some a little further out and a few anywhere at all.
  function automatic logic signed [15:0] pick_coord(logic signed [15:0] lo, hi);
    int                 r, span;
    logic signed [15:0] v;
    r = $urandom_range(0, 99);
    span = int'(hi) - int'(lo);
    if (r < 65) begin
      v = clamp_coord(int'(lo) - 3 + int'($urandom_range(0, span + 6)));
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       v = clamp_coord(int'(lo) - 1);
        1:       v = lo;
        2:       v = hi;
        default: v = clamp_coord(int'(hi) + 1);
      endcase
    end else if (r < 95) begin
      v = clamp_coord(int'($urandom_range(0, 1200)) - 600);
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  function automatic swbs_pkg::in_item_t random_word();
    swbs_pkg::in_item_t w;
    int                 r, k;
    r = $urandom_range(0, 99);
    if (r < 46) w.opcode = swbs_pkg::OP_WRITE;
    else if (r < 91) w.opcode = swbs_pkg::OP_READ;
    else if (r < 95) w.opcode = swbs_pkg::OP_RESTART;
    else w.opcode = OP_UNUSED;
    w.x_coord = pick_coord(win_x_lo, win_x_hi);
    w.y_coord = pick_coord(win_y_lo, win_y_hi);
    w.write_bit = ($urandom_range(0, 9) < 7);
    if (w.opcode == swbs_pkg::OP_READ && recent_cells.size() > 0 &&
        $urandom_range(0, 2) == 0) begin
      k = $urandom_range(0, recent_cells.size() - 1);
      {w.x_coord, w.y_coord} = recent_cells[k];
    end
    return w;
  endfunction

  // Offers one word and waits for it to be taken. The caller is always just
  // past a rising edge, so valid changes at most once in any time step, and
  // it stays high between back-to-back words.
  task automatic send_word(input swbs_pkg::in_item_t w);
    int unsigned       gap;
    cell_expectation_t e;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (!in_ready);
    e.word = w;
    e.result = apply_word(w);
    pending_results.push_back(e);
    words_sent++;
  endtask

  task automatic send_cell(input logic [1:0] op, input logic signed [15:0] x, y,
                           input logic wbit);
    swbs_pkg::in_item_t w;
    w.opcode = op;
    w.x_coord = x;
    w.y_coord = y;
    w.write_bit = wbit;
    send_word(w);
  endtask

  // Drops valid and holds the input idle until every predicted result has
  // come out of the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, and a long hold-off when a test asks for one.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void note_mismatch(string msg);
    failures++;
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Every result word taken from the block is checked against the oldest
  // prediction. Values read here are those from just before the edge.
  always @(posedge clk) begin
    cell_expectation_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("%0t: result word with nothing outstanding: read_bit %0b in_window %0b",
                                $realtime, out_item.read_bit, out_item.in_window));
      end else begin
        e = pending_results.pop_front();
        if (out_item.read_bit !== e.result.read_bit)
          note_mismatch($sformatf("%0t: op %0d at (%0d,%0d): read_bit expected %0b, got %0b",
                                  $realtime, e.word.opcode, e.word.x_coord, e.word.y_coord,
                                  e.result.read_bit, out_item.read_bit));
        if (out_item.in_window !== e.result.in_window)
          note_mismatch($sformatf("%0t: op %0d at (%0d,%0d): in_window expected %0b, got %0b",
                                  $realtime, e.word.opcode, e.word.x_coord, e.word.y_coord,
                                  e.result.in_window, out_item.in_window));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked words: coordinate extremes, writes outside the window, the
  // window collapsing onto a full-width box, aliasing on the torus, writes of
  // zero, restarts that keep the map, and the unused opcode.
  task automatic test_directed_cases();
    send_cell(swbs_pkg::OP_READ, 0, 0, 1'b0);               // cleared map reads as free
    send_cell(swbs_pkg::OP_READ, -32768, -32768, 1'b1);     // far outside reads as occupied
    send_cell(swbs_pkg::OP_READ, 32767, 32767, 1'b0);
    send_cell(swbs_pkg::OP_WRITE, 32767, 0, 1'b1);          // outside, ignored
    send_cell(swbs_pkg::OP_WRITE, 0, -32768, 1'b1);         // outside, ignored
    send_cell(swbs_pkg::OP_WRITE, 0, 0, 1'b1);
    send_cell(swbs_pkg::OP_READ, 0, 0, 1'b0);
    send_cell(swbs_pkg::OP_WRITE, -128, 5, 1'b1);
    send_cell(swbs_pkg::OP_RESTART, 0, 0, 1'b0);
    send_cell(swbs_pkg::OP_READ, 128, 5, 1'b0);             // same row as -128 on the torus
    send_cell(swbs_pkg::OP_WRITE, 255, 255, 1'b1);          // box now a full grid wide
    send_cell(swbs_pkg::OP_READ, -1, 0, 1'b0);              // just outside the collapsed window
    send_cell(swbs_pkg::OP_READ, 255, 255, 1'b0);
    send_cell(swbs_pkg::OP_WRITE, 255, 255, 1'b0);          // write of zero on a set cell
    send_cell(swbs_pkg::OP_READ, 255, 255, 1'b1);
    send_cell(swbs_pkg::OP_WRITE, -1, -1, 1'b1);            // outside, ignored
    send_cell(swbs_pkg::OP_RESTART, -1, -1, 1'b1);
    send_cell(swbs_pkg::OP_WRITE, -255, -255, 1'b1);        // far corner of the widest window
    send_cell(swbs_pkg::OP_READ, 1, 1, 1'b0);
    send_cell(swbs_pkg::OP_READ, -255, -255, 1'b0);
    send_cell(OP_UNUSED, -1, -1, 1'b1);
    send_cell(swbs_pkg::OP_READ, 0, 0, 1'b0);               // still set from before the restarts
    send_cell(swbs_pkg::OP_RESTART, 32767, -32768, 1'b0);
    send_cell(swbs_pkg::OP_WRITE, 100, -100, 1'b0);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_word(random_word());
  endtask

  // No idling on either side, so words follow one another as fast as the
  // block allows.
  task automatic test_back_to_back(int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_word(random_word());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The result side holds off for a long stretch while words keep being
  // offered, so the block fills up and has to stall its input.
  task automatic test_output_hold_off(int count);
    hold_off_request = HOLD_OFF_CYCLES;
    tx_idle_en = 1'b0;
    repeat (count) send_word(random_word());
    tx_idle_en = 1'b1;
  endtask

  // The input waits until the block has emptied, then carries on.
  task automatic test_after_drain(int count);
    wait_drained();
    repeat (count) send_word(random_word());
  endtask

  initial begin
    for (int r = 0; r < GRID_CELLS; r++)
      for (int c = 0; c < GRID_CELLS; c++)
        occupancy[r][c] = 1'b0;
    recentre_box();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass after reset shows only as in_ready held low.
    test_directed_cases();
    test_random_mix(440);
    test_back_to_back(60);
    test_output_hold_off(60);
    test_after_drain(40);

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    failures += pending_results.size();

    $display("Run covered %0d words and %0d results: %0d reads (%0d inside the window),",
             words_sent, results_seen, n_reads, n_reads_inside);
    $display("%0d writes (%0d taken), %0d restarts, %0d unused; widest box %0d cells.",
             n_writes, n_writes_taken, n_restarts, n_unused, widest_span);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
